// File: rtl/core/fat12_cluster_chain_allocator_unit_defines.svh
// Assertion macros for the allocator checker
`ifndef FAT12_CLUSTER_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FAT12_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FAT12_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fat12_pkg.sv
// Package: constants and payload types of the FAT12 cluster chain allocator
package fat12_pkg;

  localparam int TABLE_BYTES     = 512;
  localparam int CLUSTER_SECTORS = 8;
  localparam int SECTOR_BYTES    = 512;
  localparam int CLUSTER_BYTES   = SECTOR_BYTES * CLUSTER_SECTORS;
  localparam int TBL_AW          = $clog2(TABLE_BYTES);

  localparam logic [11:0] LAST_CLUSTER = 12'hFF6;
  localparam logic [11:0] END_MARK     = 12'hFFF;
  localparam logic [11:0] FIRST_FREE   = 12'd2;
  localparam logic [20:0] COUNT_MAX    = 21'h1FFFFF;
  localparam logic [24:0] DISK_RESET   = 25'd8388608;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] file_length;
    logic [8:0]  table_byte_address;
  } fat12_in_t;

  typedef struct packed {
    logic [11:0] head_cluster;
    logic [20:0] cluster_count;
    logic [15:0] start_sector;
    logic        start_valid;
    logic        no_room;
    logic [7:0]  table_byte;
  } fat12_out_t;

endpackage

// File: rtl/core/fat12_sector.sv
// Start sector of a chain from the disk size register and the first cluster
module fat12_sector (
  input  logic [24:0] size_bytes,
  input  logic [11:0] head_cluster,
  output logic [15:0] start_sector
);

  localparam int SECTOR_BYTES = fat12_pkg::SECTOR_BYTES;

  logic [15:0] total_sec;
  logic [31:0] fat_units;
  logic [15:0] fat_sec;
  logic [15:0] data_sec;
  logic [15:0] clus_off;

  // Total sectors wrap to 16 bits, as a 16-bit sector register would
  assign total_sec = 16'((32'(size_bytes) + 32'd65536) / SECTOR_BYTES);
  assign fat_units = (32'(total_sec) / fat12_pkg::CLUSTER_SECTORS + 32'd1023) / 32'd1024;
  assign fat_sec   = 16'(32'd3 * fat_units);
  // Boot sector, two FAT copies, two root directory sectors
  assign data_sec  = 16'd3 + 16'(fat_sec << 1);
  assign clus_off  = 16'((32'(head_cluster) - 32'd2) * fat12_pkg::CLUSTER_SECTORS);
  assign start_sector = data_sec + clus_off;

endmodule

// File: rtl/core/fat12_cluster_chain_allocator_unit.sv
// Top level: FAT12 cluster chain allocator with packed table memory
//
// The block holds a packed FAT12 table (TABLE_BYTES bytes, two 12-bit entries
// in every three bytes) in one synchronous single-port-write, single-port-read
// memory, plus the next free cluster index. An allocate request takes
// ceil(length / cluster bytes) contiguous clusters from the next free one,
// links each to the next and closes the chain with 0xFFF; a request whose
// chain would run past cluster 0xFF6 or off the end of the table is answered
// with no_room and changes nothing. A read request returns one table byte
// (0 beyond the table). Requests are handled one at a time. A read addresses
// the memory in S_CHECK and takes the byte in S_RDWAIT. An allocate writes
// table bytes lo(first) to hi(last) (about 1.5 bytes per cluster): the walk
// reads one byte and writes the merged previous byte each cycle through the
// memory ports. Zero-length and no-room requests go from S_CHECK straight to
// S_PUSH. A finished result waits in S_PUSH until the output register is
// free; while that register holds it, the next request can be accepted.
// After reset a clearing pass over all TABLE_BYTES bytes loads F8 FF FF and
// then zeros, during which no request is accepted; disk size writes are
// taken at any time and only change the reported start sector.
module fat12_cluster_chain_allocator_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fat12_pkg::fat12_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fat12_pkg::fat12_out_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [24:0]           cfg_wr_data
);

  localparam int AW = fat12_pkg::TBL_AW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  // Table memory
  logic [7:0]  tbl_mem [fat12_pkg::TABLE_BYTES];
  logic [7:0]  rd_data_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]  mem_wd;
  logic        mem_re;
  logic [AW-1:0] mem_ra;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [24:0]   disk_r, disk_nxt;
  logic [11:0]   free_r, free_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          rd_act_r, rd_act_nxt;
  logic          pend_v_r, pend_v_nxt;

  // Payload and walk registers
  fat12_pkg::fat12_in_t  item_r, item_nxt;
  logic [20:0]           cnt_r, cnt_nxt;
  fat12_pkg::fat12_out_t res_r, res_nxt;
  fat12_pkg::fat12_out_t out_r, out_nxt;
  logic [11:0]   f_r, f_nxt;
  logic [11:0]   last_r, last_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic [AW-1:0] end_b_r, end_b_nxt;
  logic [1:0]    m_r, m_nxt;
  logic [11:0]   e_r, e_nxt;
  logic [AW-1:0] pend_b_r, pend_b_nxt;
  logic [1:0]    pend_m_r, pend_m_nxt;
  logic [11:0]   pend_e_r, pend_e_nxt;

  // Combinational helpers
  logic [32:0] len_up;
  logic [32:0] n_full;
  logic [20:0] n_sat;
  logic [22:0] last_w;
  logic [23:0] lo_last_w;
  logic [31:0] hi_last_w;
  logic [31:0] lo_free_w;
  logic        fits_w;
  logic [31:0] rd_addr_ext;
  logic        rd_in_range;
  logic [15:0] start_sec;
  logic [7:0]  clr_byte;
  logic [7:0]  merged;
  logic [11:0] e1_w;
  logic        in0_w, in1_w;
  logic [11:0] v0_w, v1_w;

  fat12_sector u_sector (
    .size_bytes   (disk_r),
    .head_cluster (free_r),
    .start_sector (start_sec)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Cluster count, rounded up and saturated to the count field
  assign len_up = 33'(in_data.file_length) + 33'(fat12_pkg::CLUSTER_BYTES - 1);
  assign n_full = len_up / fat12_pkg::CLUSTER_BYTES;
  assign n_sat  = (n_full > 33'(fat12_pkg::COUNT_MAX)) ? fat12_pkg::COUNT_MAX : n_full[20:0];

  // Fit check: the last entry must be a valid cluster and lie wholly in the table
  assign last_w    = 23'(free_r) + 23'(cnt_r) - 23'd1;
  assign lo_last_w = 24'(last_w) + 24'(last_w >> 1);
  assign hi_last_w = 32'(lo_last_w) + 32'd1;
  assign lo_free_w = 32'(free_r) + 32'(free_r >> 1);
  assign fits_w    = (cnt_r != 21'd0) && (last_w <= 23'(fat12_pkg::LAST_CLUSTER)) &&
                     (hi_last_w < 32'(fat12_pkg::TABLE_BYTES));

  assign rd_addr_ext = 32'(item_r.table_byte_address);
  assign rd_in_range = (rd_addr_ext < 32'(fat12_pkg::TABLE_BYTES));

  // Reset image: media entry 0xFF8, end mark 0xFFF, rest free
  always_comb begin
    if (clr_addr_r == AW'(0)) begin
      clr_byte = 8'hF8;
    end else if (32'(clr_addr_r) inside {32'd1, 32'd2}) begin
      clr_byte = 8'hFF;
    end else begin
      clr_byte = 8'h00;
    end
  end

  // Merge one pending byte: entries 2g and 2g+1 share bytes 3g..3g+2
  assign e1_w  = pend_e_r + 12'd1;
  assign in0_w = (pend_e_r >= f_r) && (pend_e_r <= last_r);
  assign in1_w = (e1_w >= f_r) && (e1_w <= last_r);
  assign v0_w  = (pend_e_r == last_r) ? fat12_pkg::END_MARK : pend_e_r + 12'd1;
  assign v1_w  = (e1_w == last_r) ? fat12_pkg::END_MARK : e1_w + 12'd1;

  always_comb begin
    case (pend_m_r)
      2'd0: begin
        merged = in0_w ? v0_w[7:0] : rd_data_r;
      end
      2'd1: begin
        merged = {in1_w ? v1_w[3:0] : rd_data_r[7:4], in0_w ? v0_w[11:8] : rd_data_r[3:0]};
      end
      2'd2: begin
        merged = in1_w ? v1_w[11:4] : rd_data_r;
      end
      default: begin
        merged = rd_data_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    disk_nxt      = disk_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    rd_act_nxt    = rd_act_r;
    pend_v_nxt    = pend_v_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    f_nxt         = f_r;
    last_nxt      = last_r;
    b_nxt         = b_r;
    end_b_nxt     = end_b_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    pend_b_nxt    = pend_b_r;
    pend_m_nxt    = pend_m_r;
    pend_e_nxt    = pend_e_r;
    mem_we        = 1'b0;
    mem_wa        = pend_b_r;
    mem_wd        = merged;
    mem_re        = 1'b0;
    mem_ra        = b_r;

    // Disk size register loads whenever written
    if (cfg_wr_en) begin
      disk_nxt = cfg_wr_data;
    end

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = clr_byte;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(fat12_pkg::TABLE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cnt_nxt   = n_sat;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_nxt = '0;
        if (item_r.opcode == fat12_pkg::OP_READ) begin
          mem_re    = 1'b1;
          mem_ra    = rd_addr_ext[AW-1:0];
          state_nxt = S_RDWAIT;
        end else if (cnt_r == 21'd0) begin
          state_nxt = S_PUSH;
        end else if (!fits_w) begin
          res_nxt.cluster_count = cnt_r;
          res_nxt.no_room       = 1'b1;
          state_nxt = S_PUSH;
        end else begin
          res_nxt.head_cluster  = free_r;
          res_nxt.cluster_count = cnt_r;
          res_nxt.start_sector  = start_sec;
          res_nxt.start_valid   = 1'b1;
          f_nxt     = free_r;
          last_nxt  = last_w[11:0];
          free_nxt  = last_w[11:0] + 12'd1;
          // Start at byte lo(first); odd entries begin mid-group
          b_nxt     = lo_free_w[AW-1:0];
          m_nxt     = free_r[0] ? 2'd1 : 2'd0;
          e_nxt     = {free_r[11:1], 1'b0};
          end_b_nxt = hi_last_w[AW-1:0];
          rd_act_nxt = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_WALK;
        end
      end
      S_RDWAIT: begin
        res_nxt.table_byte = rd_in_range ? rd_data_r : 8'h00;
        state_nxt = S_PUSH;
      end
      S_WALK: begin
        // Write back the byte read last cycle
        mem_we = pend_v_r;
        if (rd_act_r) begin
          mem_re     = 1'b1;
          pend_v_nxt = 1'b1;
          pend_b_nxt = b_r;
          pend_m_nxt = m_r;
          pend_e_nxt = e_r;
          b_nxt      = b_r + AW'(1);
          if (m_r == 2'd2) begin
            m_nxt = 2'd0;
            e_nxt = e_r + 12'd2;
          end else begin
            m_nxt = m_r + 2'd1;
          end
          if (b_r == end_b_r) begin
            rd_act_nxt = 1'b0;
          end
        end else begin
          pend_v_nxt = 1'b0;
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      disk_r      <= fat12_pkg::DISK_RESET;
      free_r      <= fat12_pkg::FIRST_FREE;
      out_valid_r <= 1'b0;
      rd_act_r    <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      disk_r      <= disk_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      rd_act_r    <= rd_act_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    f_r      <= f_nxt;
    last_r   <= last_nxt;
    b_r      <= b_nxt;
    end_b_r  <= end_b_nxt;
    m_r      <= m_nxt;
    e_r      <= e_nxt;
    pend_b_r <= pend_b_nxt;
    pend_m_r <= pend_m_nxt;
    pend_e_r <= pend_e_nxt;
  end

endmodule

// File: rtl/core/fat12_chk.sv
// Port checker for the allocator, bound to the top level
`include "fat12_cluster_chain_allocator_unit_defines.svh"

module fat12_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input fat12_pkg::fat12_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input fat12_pkg::fat12_out_t out_data
);

  `FAT12_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `FAT12_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while one is in flight")
  `FAT12_ASSERT_IMP(a_flags_excl, out_valid, !(out_data.start_valid && out_data.no_room), "start_valid and no_room both set")
  `FAT12_ASSERT_IMP(a_chain_ok, out_valid && out_data.start_valid, out_data.head_cluster >= 12'd2 && out_data.cluster_count != 21'd0 && out_data.table_byte == 8'h00, "bad chain result")
  `FAT12_ASSERT_IMP(a_noroom_ok, out_valid && out_data.no_room, out_data.head_cluster == 12'd0 && out_data.start_sector == 16'd0 && out_data.cluster_count != 21'd0, "bad no-room result")

endmodule

bind fat12_cluster_chain_allocator_unit fat12_chk u_chk (.*);
